// ===== src/assert_macros.svh =====
// Assertion macros for the RTL modules; included by the pin sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lcdnw_pkg.sv =====
// Types and constants of the character LCD nibble writer.
package lcdnw_pkg;

    // Item kinds
    localparam logic [2:0] FUNC_COMMAND = 3'd0;
    localparam logic [2:0] FUNC_CHAR    = 3'd1;
    localparam logic [2:0] FUNC_DATA    = 3'd2;
    localparam logic [2:0] FUNC_CURSOR  = 3'd3;
    localparam logic [2:0] FUNC_NUMBER  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_DATA_WAIT    = 2'd1;
    localparam logic [1:0] CFG_COMMAND_WAIT = 2'd2;

    // Configuration reset values
    localparam logic [6:0]  LINE_LENGTH_RESET  = 7'd16;
    localparam logic [15:0] DATA_WAIT_RESET    = 16'd50;
    localparam logic [15:0] COMMAND_WAIT_RESET = 16'd5000;

    // LCD codes
    localparam logic [7:0] CMD_ROW1_COL0 = 8'hC0;
    localparam logic       CMD_ADDR_FLAG = 1'b1;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_ONE     = 8'h31;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_X       = 8'h78;
    localparam logic [7:0] NUMBER_TWO_DIGIT = 8'd10;
    localparam logic [7:0] NUMBER_MAX       = 8'd19;

    // A job holds at most three byte operations
    localparam int OPS_MAX = 3;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic       row;
        logic [5:0] column;
    } item_t;

    typedef struct packed {
        logic        reg_select;
        logic        enable;
        logic [3:0]  data_nibble;
        logic [15:0] wait_us;
        logic        last;
    } pin_t;

    typedef struct packed {
        logic       is_cmd;
        logic [7:0] code;
    } op_t;

    typedef struct packed {
        logic [1:0]         op_count;
        op_t [OPS_MAX-1:0]  ops;
    } job_t;

endpackage

// ===== src/char_lcd_nibble_writer.sv =====
// Top level of the character LCD nibble writer: config registers, front end, queue, sequencer.
// The first pin state of an item passes the job queue and the sequencer's output register.
// Throughput: one pin state per cycle while the receiver is ready; an item has 6 to 20
// pin states, paced by the pin sequencer; unused item kinds are taken with no output.
// The job queue lets new items transfer while the sequencer is still busy.
// Reset (rst_n low, async): config to 16 / 50 / 5000, cursor, RS and nibble to zero.
module char_lcd_nibble_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    // item channel
    input  logic             item_valid,
    output logic             item_ready,
    input  lcdnw_pkg::item_t item,
    // pin state channel
    output logic             pin_valid,
    input  logic             pin_ready,
    output lcdnw_pkg::pin_t  pin,
    // config write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    logic [6:0]      line_length_reg;
    logic [15:0]     data_wait_reg;
    logic [15:0]     command_wait_reg;

    logic            push_valid;
    logic            push_ready;
    lcdnw_pkg::job_t push_job;
    logic            pop_valid;
    logic            pop_ready;
    lcdnw_pkg::job_t pop_job;

    // Config writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg  <= lcdnw_pkg::LINE_LENGTH_RESET;
            data_wait_reg    <= lcdnw_pkg::DATA_WAIT_RESET;
            command_wait_reg <= lcdnw_pkg::COMMAND_WAIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcdnw_pkg::CFG_LINE_LENGTH:  line_length_reg  <= cfg_data[6:0];
                lcdnw_pkg::CFG_DATA_WAIT:    data_wait_reg    <= cfg_data;
                lcdnw_pkg::CFG_COMMAND_WAIT: command_wait_reg <= cfg_data;
                default:                     line_length_reg  <= line_length_reg;
            endcase
        end
    end

    // Front end: decode the item into up to three byte ops, track the cursor.
    lcdnw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .line_length (line_length_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    // Job queue decouples decoding from the pin sequence.
    lcdnw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back end: emits RS / E / nibble states with their hold times.
    lcdnw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (pop_valid),
        .job_ready       (pop_ready),
        .job             (pop_job),
        .data_wait_us    (data_wait_reg),
        .command_wait_us (command_wait_reg),
        .pin_valid       (pin_valid),
        .pin_ready       (pin_ready),
        .pin             (pin)
    );

endmodule

// ===== src/lcdnw_front.sv =====
// Front end: accepts items, tracks the cursor and turns each item into a job of byte ops.
module lcdnw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  lcdnw_pkg::item_t     item,
    input  logic [6:0]           line_length,
    output logic                 push_valid,
    input  logic                 push_ready,
    output lcdnw_pkg::job_t      push_job
);

    logic [7:0]      cursor_reg;
    logic [7:0]      cursor_next;
    logic [7:0]      limit;
    logic            wrap1;
    logic            wrap2;
    logic [7:0]      col1;
    logic [7:0]      col2;
    logic            has_ops;
    lcdnw_pkg::job_t job;

    assign limit = {1'b0, line_length};
    assign wrap1 = (cursor_reg == limit);
    assign col1  = (wrap1 ? 8'd0 : cursor_reg) + 8'd1;
    // only one wrap per number item
    assign wrap2 = !wrap1 && (col1 == limit);
    assign col2  = (wrap2 ? 8'd0 : col1) + 8'd1;

    always_comb
    begin
        job         = '0;
        has_ops     = 1'b1;
        cursor_next = cursor_reg;
        unique case (item.func)
            lcdnw_pkg::FUNC_COMMAND:
            begin
                job.op_count = 2'd1;
                job.ops[0]   = '{is_cmd: 1'b1, code: item.value};
            end
            lcdnw_pkg::FUNC_CHAR:
            begin
                if (wrap1)
                begin
                    job.op_count = 2'd2;
                    job.ops[0]   = '{is_cmd: 1'b1, code: lcdnw_pkg::CMD_ROW1_COL0};
                    job.ops[1]   = '{is_cmd: 1'b0, code: item.value};
                end
                else
                begin
                    job.op_count = 2'd1;
                    job.ops[0]   = '{is_cmd: 1'b0, code: item.value};
                end
                cursor_next = col1;
            end
            lcdnw_pkg::FUNC_DATA:
            begin
                job.op_count = 2'd1;
                job.ops[0]   = '{is_cmd: 1'b0, code: item.value};
            end
            lcdnw_pkg::FUNC_CURSOR:
            begin
                job.op_count = 2'd1;
                job.ops[0]   = '{is_cmd: 1'b1,
                                 code: {lcdnw_pkg::CMD_ADDR_FLAG, item.row, item.column}};
                cursor_next  = {2'b00, item.column};
            end
            lcdnw_pkg::FUNC_NUMBER:
            begin
                if (item.value > lcdnw_pkg::NUMBER_MAX)
                begin
                    // "xx", tracked
                    if (wrap1 || wrap2)
                    begin
                        job.op_count = 2'd3;
                        if (wrap1)
                        begin
                            job.ops[0] = '{is_cmd: 1'b1, code: lcdnw_pkg::CMD_ROW1_COL0};
                            job.ops[1] = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_X};
                        end
                        else
                        begin
                            job.ops[0] = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_X};
                            job.ops[1] = '{is_cmd: 1'b1, code: lcdnw_pkg::CMD_ROW1_COL0};
                        end
                        job.ops[2]   = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_X};
                    end
                    else
                    begin
                        job.op_count = 2'd2;
                        job.ops[0]   = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_X};
                        job.ops[1]   = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_X};
                    end
                    cursor_next = col2;
                end
                else if (item.value >= lcdnw_pkg::NUMBER_TWO_DIGIT)
                begin
                    job.op_count = 2'd2;
                    job.ops[0]   = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_ONE};
                    job.ops[1]   = '{is_cmd: 1'b0,
                        code: item.value - lcdnw_pkg::NUMBER_TWO_DIGIT + lcdnw_pkg::ASCII_ZERO};
                end
                else
                begin
                    job.op_count = 2'd2;
                    job.ops[0]   = '{is_cmd: 1'b0,
                                     code: item.value + lcdnw_pkg::ASCII_ZERO};
                    job.ops[1]   = '{is_cmd: 1'b0, code: lcdnw_pkg::ASCII_SPACE};
                end
            end
            default:
            begin
                has_ops = 1'b0;  // unused kinds are dropped
            end
        endcase
    end

    assign item_ready = push_ready;
    assign push_valid = item_valid && has_ops;
    assign push_job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= 8'd0;
        end
        else if (item_valid && item_ready)
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

// ===== src/lcdnw_queue.sv =====
// Small job queue between the front end and the pin sequencer.
module lcdnw_queue #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  lcdnw_pkg::job_t  push_job,
    output logic             pop_valid,
    input  logic             pop_ready,
    output lcdnw_pkg::job_t  pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    lcdnw_pkg::job_t  slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/lcdnw_back.sv =====
// Pin sequencer: walks the byte ops of each job, one pin state per cycle while pin_ready.
`include "assert_macros.svh"

module lcdnw_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  lcdnw_pkg::job_t  job,
    input  logic [15:0]      data_wait_us,
    input  logic [15:0]      command_wait_us,
    output logic             pin_valid,
    input  logic             pin_ready,
    output lcdnw_pkg::pin_t  pin
);

    // Steps of one byte; a data byte runs steps 1..6, a command 0..7
    localparam logic [2:0] STEP_RS_LOW    = 3'd0;
    localparam logic [2:0] STEP_HI_E_RISE = 3'd1;
    localparam logic [2:0] STEP_HI_SET    = 3'd2;
    localparam logic [2:0] STEP_HI_E_FALL = 3'd3;
    localparam logic [2:0] STEP_LO_E_RISE = 3'd4;
    localparam logic [2:0] STEP_LO_SET    = 3'd5;
    localparam logic [2:0] STEP_LO_E_FALL = 3'd6;
    localparam logic [2:0] STEP_RS_HIGH   = 3'd7;

    logic             busy_reg;
    lcdnw_pkg::job_t  job_reg;
    logic [1:0]       idx_reg;
    logic [2:0]       step_reg;
    logic             rs_reg;
    logic [3:0]       nib_reg;
    logic             out_valid_reg;
    lcdnw_pkg::pin_t  out_reg;

    lcdnw_pkg::job_t  cur_job;
    logic [1:0]       cur_idx;
    logic [1:0]       next_idx;
    lcdnw_pkg::op_t   cur_op;
    lcdnw_pkg::op_t   next_op;
    logic [2:0]       cur_step;
    logic [2:0]       end_step;
    logic             advance;
    logic             fire;
    logic             op_done;
    logic             job_done;
    logic             rs_out;
    logic             en_out;
    logic [3:0]       nib_out;
    logic [15:0]      wait_out;

    assign cur_job  = busy_reg ? job_reg : job;
    assign cur_idx  = busy_reg ? idx_reg : 2'd0;
    assign next_idx = cur_idx + 2'd1;
    assign cur_op   = cur_job.ops[cur_idx];
    assign next_op  = cur_job.ops[(next_idx == 2'd3) ? 2'd2 : next_idx];
    assign cur_step = busy_reg ? step_reg
                               : (cur_op.is_cmd ? STEP_RS_LOW : STEP_HI_E_RISE);
    assign end_step = cur_op.is_cmd ? STEP_RS_HIGH : STEP_LO_E_FALL;
    assign op_done  = (cur_step == end_step);
    assign job_done = op_done && (cur_idx == cur_job.op_count - 2'd1);

    assign advance   = !out_valid_reg || pin_ready;
    assign fire      = advance && (busy_reg || job_valid);
    assign job_ready = advance && !busy_reg;

    always_comb
    begin
        rs_out   = rs_reg;
        nib_out  = nib_reg;
        en_out   = 1'b0;
        wait_out = 16'd0;
        unique case (cur_step)
            STEP_RS_LOW:    rs_out = 1'b0;
            STEP_HI_E_RISE: en_out = 1'b1;
            STEP_HI_SET:
            begin
                en_out  = 1'b1;
                nib_out = cur_op.code[7:4];
            end
            STEP_HI_E_FALL: en_out = 1'b0;
            STEP_LO_E_RISE: en_out = 1'b1;
            STEP_LO_SET:
            begin
                en_out  = 1'b1;
                nib_out = cur_op.code[3:0];
            end
            STEP_LO_E_FALL: wait_out = data_wait_us;
            STEP_RS_HIGH:
            begin
                rs_out   = 1'b1;
                wait_out = command_wait_us;
            end
            default:        en_out = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            job_reg       <= '0;
            idx_reg       <= 2'd0;
            step_reg      <= STEP_RS_LOW;
            rs_reg        <= 1'b0;
            nib_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (fire)
        begin
            rs_reg        <= rs_out;
            nib_reg       <= nib_out;
            out_valid_reg <= 1'b1;
            out_reg       <= '{reg_select: rs_out, enable: en_out, data_nibble: nib_out,
                               wait_us: wait_out, last: job_done};
            if (!busy_reg)
            begin
                job_reg <= job;
            end
            busy_reg <= !job_done;
            if (op_done)
            begin
                idx_reg  <= next_idx;
                step_reg <= next_op.is_cmd ? STEP_RS_LOW : STEP_HI_E_RISE;
            end
            else
            begin
                idx_reg  <= cur_idx;
                step_reg <= cur_step + 3'd1;
            end
        end
        else if (pin_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pin_valid = out_valid_reg;
    assign pin       = out_reg;

    `ASSERT_IMPLIES(a_pop_when_idle, clk, rst_n, job_valid && job_ready, !busy_reg,
        "job taken while another is in progress")
    `ASSERT_NEXT(a_job_spans_cycles, clk, rst_n, fire && !busy_reg, busy_reg,
        "job finished in its first step")
    `ASSERT_IMPLIES(a_strobe_no_wait, clk, rst_n, pin_valid && pin.enable,
        pin.wait_us == 16'd0 && !pin.last, "E high with a hold time or on the final state")

endmodule

// ===== test/tb_char_lcd_nibble_writer.sv =====
// Self-checking testbench for the character LCD nibble writer.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_writer;

    // Item kinds that the block ignores
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_MID   = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
    // Register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    lcdnw_pkg::item_t  item = '0;
    logic              pin_valid;
    logic              pin_ready = 1'b0;
    lcdnw_pkg::pin_t   pin;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;

    char_lcd_nibble_writer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pin_valid  (pin_valid),
        .pin_ready  (pin_ready),
        .pin        (pin),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pin sequence predictor: own copy of the LCD pin state, cursor and
    // configuration, expanded per accepted item into expected pin states.
    // ------------------------------------------------------------------
    logic        lcd_rs     = 1'b0;
    logic [3:0]  lcd_nibble = '0;
    logic [7:0]  lcd_cursor = '0;
    logic [6:0]  line_len   = lcdnw_pkg::LINE_LENGTH_RESET;
    logic [15:0] data_hold  = lcdnw_pkg::DATA_WAIT_RESET;
    logic [15:0] cmd_hold   = lcdnw_pkg::COMMAND_WAIT_RESET;

    lcdnw_pkg::pin_t  item_pins[$];      // pin states of the item being expanded
    lcdnw_pkg::pin_t  expected_pins[$];  // pin states still owed by the block
    lcdnw_pkg::item_t pending_items[$];  // items not yet transferred

    int  err_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b0;
    int  item_gap = 0;
    int  ready_gap = 0;
    bit  item_taken = 1'b0;

    function automatic string pin_text(lcdnw_pkg::pin_t p);
        return $sformatf("rs=%0d e=%0d d=%h wait=%0d last=%0d",
                         p.reg_select, p.enable, p.data_nibble, p.wait_us, p.last);
    endfunction

    function automatic void add_pin(logic strobe, logic [15:0] hold);
        lcdnw_pkg::pin_t p;
        p.reg_select  = lcd_rs;
        p.enable      = strobe;
        p.data_nibble = lcd_nibble;
        p.wait_us     = hold;
        p.last        = 1'b0;
        item_pins.push_back(p);
    endfunction

    // E rises on old data, data changes, E falls
    function automatic void add_nibble(logic [3:0] nib, logic [15:0] final_hold);
        add_pin(1'b1, '0);
        lcd_nibble = nib;
        add_pin(1'b1, '0);
        add_pin(1'b0, final_hold);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        add_nibble(b[7:4], '0);
        add_nibble(b[3:0], data_hold);
    endfunction

    function automatic void add_command(logic [7:0] b);
        lcd_rs = 1'b0;
        add_pin(1'b0, '0);
        add_byte(b);
        lcd_rs = 1'b1;
        add_pin(1'b0, cmd_hold);
    endfunction

    // returns 1 when the move to row 1 was issued
    function automatic logic add_tracked(logic [7:0] c, logic may_wrap);
        logic wrapped;
        wrapped = 1'b0;
        if (may_wrap && lcd_cursor == {1'b0, line_len})
        begin
            add_command(lcdnw_pkg::CMD_ROW1_COL0);
            lcd_cursor = '0;
            wrapped = 1'b1;
        end
        add_byte(c);
        lcd_cursor = lcd_cursor + 8'd1;
        return wrapped;
    endfunction

    function automatic void expand_item(lcdnw_pkg::item_t it);
        logic             wrapped;
        lcdnw_pkg::pin_t  tail;
        item_pins.delete();
        case (it.func)
            lcdnw_pkg::FUNC_COMMAND: add_command(it.value);
            lcdnw_pkg::FUNC_CHAR:    void'(add_tracked(it.value, 1'b1));
            lcdnw_pkg::FUNC_DATA:    add_byte(it.value);
            lcdnw_pkg::FUNC_CURSOR:
            begin
                add_command({lcdnw_pkg::CMD_ADDR_FLAG, it.row, it.column});
                lcd_cursor = {2'b00, it.column};
            end
            lcdnw_pkg::FUNC_NUMBER:
            begin
                if (it.value > lcdnw_pkg::NUMBER_MAX)
                begin
                    // "xx": the second x never wraps after the first did
                    wrapped = add_tracked(lcdnw_pkg::ASCII_X, 1'b1);
                    void'(add_tracked(lcdnw_pkg::ASCII_X, !wrapped));
                end
                else if (it.value >= lcdnw_pkg::NUMBER_TWO_DIGIT)
                begin
                    add_byte(lcdnw_pkg::ASCII_ZERO + it.value / 8'd10);
                    add_byte(lcdnw_pkg::ASCII_ZERO + it.value % 8'd10);
                end
                else
                begin
                    add_byte(lcdnw_pkg::ASCII_ZERO + it.value);
                    add_byte(lcdnw_pkg::ASCII_SPACE);
                end
            end
            default: ;
        endcase
        if (item_pins.size() > 0)
        begin
            tail = item_pins[item_pins.size() - 1];
            tail.last = 1'b1;
            item_pins[item_pins.size() - 1] = tail;
        end
        foreach (item_pins[i])
            expected_pins.push_back(item_pins[i]);
    endfunction

    // Mostly short gaps, a few long ones; none while idling is off
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic lcdnw_pkg::item_t make_item(logic [2:0] f, logic [7:0] v, logic r,
                                                   logic [5:0] c);
        lcdnw_pkg::item_t it;
        it.func   = f;
        it.value  = v;
        it.row    = r;
        it.column = c;
        return it;
    endfunction

    // Well-formed random item; chars and numbers dominate so the cursor
    // keeps running into the wrap point
    function automatic lcdnw_pkg::item_t random_item();
        lcdnw_pkg::item_t it;
        int    r;
        int    hi;
        int    lo;
        it.value  = 8'($urandom_range(0, 255));
        it.row    = 1'($urandom_range(0, 1));
        it.column = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 35)
            it.func = lcdnw_pkg::FUNC_CHAR;
        else if (r < 55)
        begin
            it.func = lcdnw_pkg::FUNC_NUMBER;
            case ($urandom_range(0, 3))
                0: it.value = 8'($urandom_range(0, 9));
                1: it.value = 8'($urandom_range(10, 19));
                2: it.value = 8'($urandom_range(20, 255));
                default: ;
            endcase
        end
        else if (r < 67)
        begin
            it.func = lcdnw_pkg::FUNC_CURSOR;
            if ($urandom_range(0, 1) == 1)
            begin
                // land at or just short of the wrap column
                hi = (line_len > 7'd63) ? 63 : int'(line_len);
                lo = (hi > 2) ? hi - 2 : 0;
                it.column = 6'($urandom_range(lo, hi));
            end
        end
        else if (r < 84)
            it.func = lcdnw_pkg::FUNC_DATA;
        else
            it.func = lcdnw_pkg::FUNC_COMMAND;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Item driver: presents the queue head at the falling edge, notes the
    // transfer at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
        begin
            expand_item(item);
            void'(pending_items.pop_front());
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_taken)
        begin
            item_taken = 1'b0;
            if (item_gap > 0)
            begin
                item_valid <= 1'b0;
                item_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                item_valid <= 1'b1;
                item <= pending_items[0];
                item_gap = pick_gap();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            pin_ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            pin_ready <= 1'b0;
            ready_gap--;
        end
        else
        begin
            pin_ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Pin monitor: every transfer is matched against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lcdnw_pkg::pin_t want;
        if (rst_n && pin_valid && pin_ready)
        begin
            if (expected_pins.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("unexpected pin state %s", pin_text(pin));
            end
            else
            begin
                want = expected_pins.pop_front();
                if (pin.reg_select !== want.reg_select || pin.enable !== want.enable ||
                    pin.data_nibble !== want.data_nibble || pin.wait_us !== want.wait_us ||
                    pin.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("pin mismatch: exp %s, got %s",
                                 pin_text(want), pin_text(pin));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence control
    // ------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lcdnw_pkg::CFG_LINE_LENGTH:  line_len  = value[6:0];
            lcdnw_pkg::CFG_DATA_WAIT:    data_hold = value;
            lcdnw_pkg::CFG_COMMAND_WAIT: cmd_hold  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Everything transferred and answered; ignored items may still be in
    // flight, so let the pipeline drain a little more
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_pins.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_burst(int count);
        int done;
        lcdnw_pkg::item_t junk;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                // ignored kind with random content
                junk = make_item(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 6'($urandom_range(0, 63)));
                pending_items.push_back(junk);
            end
            else
            begin
                pending_items.push_back(random_item());
                done++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass at reset configuration (line length 16)
        idle_on = 1'b1;
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_COMMAND, 8'h00, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_COMMAND, 8'hFF, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_DATA,    8'h00, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_DATA,    8'hFF, 1'b1, 6'd63));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_DATA,    8'hA5, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CHAR,    8'h41, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CURSOR,  8'h00, 1'b1, 6'd63));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CURSOR,  8'hFF, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CURSOR,  8'h00, 1'b0, 6'd15));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CHAR,    8'h5A, 1'b0, 6'd0));
        // cursor now at the line length: this one moves to row 1 first
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CHAR,    8'h61, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd0,  1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd9,  1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd10, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd19, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd20, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd255, 1'b0, 6'd0));
        pending_items.push_back(make_item(FUNC_UNUSED_FIRST, 8'hFF, 1'b1, 6'd63));
        pending_items.push_back(make_item(FUNC_UNUSED_MID,   8'h00, 1'b0, 6'd0));
        pending_items.push_back(make_item(FUNC_UNUSED_LAST,  8'h55, 1'b1, 6'd21));
        // "xx" straddling the wrap: second x moves to row 1
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CURSOR,  8'h00, 1'b0, 6'd15));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd200, 1'b0, 6'd0));
        // "xx" starting at the wrap: first x moves, second does not
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CURSOR,  8'h00, 1'b1, 6'd16));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_NUMBER,  8'd20, 1'b0, 6'd0));
        pending_items.push_back(make_item(lcdnw_pkg::FUNC_CHAR,    8'h7E, 1'b0, 6'd42));
        wait_drained();

        // Line length 1: the second x of a number would wrap again
        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'd1);
        write_reg(lcdnw_pkg::CFG_DATA_WAIT, 16'd0);
        write_reg(lcdnw_pkg::CFG_COMMAND_WAIT, 16'hFFFF);
        random_burst(45);

        // Line length zero: wrap only at column 0
        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'd0);
        write_reg(lcdnw_pkg::CFG_DATA_WAIT, 16'hFFFF);
        write_reg(lcdnw_pkg::CFG_COMMAND_WAIT, 16'd0);
        random_burst(40);

        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'd64);
        write_reg(lcdnw_pkg::CFG_DATA_WAIT, 16'($urandom_range(0, 65535)));
        write_reg(lcdnw_pkg::CFG_COMMAND_WAIT, 16'($urandom_range(0, 65535)));
        random_burst(45);

        // upper data bits must be dropped: line length becomes 127
        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'hFFFF);
        write_reg(lcdnw_pkg::CFG_DATA_WAIT, 16'h5555);
        write_reg(lcdnw_pkg::CFG_COMMAND_WAIT, 16'hAAAA);
        random_burst(40);

        // short lines wrap often; the unmapped index must change nothing
        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'($urandom_range(1, 8)));
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        write_reg(lcdnw_pkg::CFG_DATA_WAIT, 16'($urandom_range(0, 65535)));
        random_burst(50);

        // back-to-back stretch with no idling on either side
        write_reg(lcdnw_pkg::CFG_LINE_LENGTH, 16'd16);
        idle_on = 1'b0;
        random_burst(50);

        if (expected_pins.size() != 0)
        begin
            err_count++;
            $display("%0d expected pin states never arrived", expected_pins.size());
        end
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
